@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on clk, idle while rst is high.
`define ASSERT_CLKD(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication into the following cycle.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

@@ hw/rtl/pid_pkg.sv @@
// Types and constants shared by the PID controller files.
package pid_pkg;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] reference;
    logic signed [31:0] measurement;
    logic signed [31:0] time_step;
  } pid_in_t;

  typedef struct packed {
    logic signed [31:0] drive_command;
    logic               limited;
  } pid_out_t;

  localparam logic [2:0] MODE_RESET   = 3'd0;
  localparam logic [2:0] MODE_STANDBY = 3'd1;
  localparam logic [2:0] MODE_HOLD    = 3'd2;
  localparam logic [2:0] MODE_INIT    = 3'd3;
  localparam logic [2:0] MODE_ENGAGE  = 3'd4;

  localparam logic [2:0] CFG_SCALE = 3'd0;
  localparam logic [2:0] CFG_CMIN  = 3'd1;
  localparam logic [2:0] CFG_CMAX  = 3'd2;
  localparam logic [2:0] CFG_KP    = 3'd3;
  localparam logic [2:0] CFG_KI    = 3'd4;
  localparam logic [2:0] CFG_KD    = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_DERR,
    ST_DISPATCH,
    ST_PE,
    ST_DE,
    ST_PRESET0,
    ST_INTEG,
    ST_IE,
    ST_PRESET1,
    ST_OUT
  } pid_state_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
    logic      wide;
  } arith_req_t;

endpackage

@@ hw/rtl/pid_arith.sv @@
// Shared shift-add multiplier and restoring divider for fixed-point operations.
module pid_arith #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  pid_pkg::arith_req_t req,
  input  logic signed [31:0]  opa,
  input  logic signed [((DATA_WIDTH + 16 > 62) ? 62 : DATA_WIDTH + 16)-1:0] opb,
  output logic                done,
  output logic signed [((DATA_WIDTH + 16 > 62) ? 62 : DATA_WIDTH + 16)-1:0] res
);
  import pid_pkg::*;

  localparam int IW   = (DATA_WIDTH + 16 > 62) ? 62 : DATA_WIDTH + 16;
  localparam int PW   = 32 + IW;
  localparam int NB   = IW + FRACTION_BITS;
  localparam int CNTW = $clog2(NB + 1);
  localparam logic [PW-1:0] DMAX = (PW'(1) << (DATA_WIDTH - 1)) - PW'(1);
  localparam logic [PW-1:0] IMAX = (PW'(1) << (IW - 1)) - PW'(1);

  logic            busy;
  arith_op_t       op;
  logic            wide;
  logic            neg;
  logic            zero;
  logic [31:0]     ma;
  logic [IW-1:0]   mb;
  logic [NB-1:0]   dv;
  logic [PW-1:0]   acc;
  logic [32:0]     rem;
  logic [CNTW-1:0] cnt;

  logic [IW-1:0] mag_b;
  logic [32:0]   rs;
  logic          qbit;
  logic [PW-1:0] m;
  logic [PW-1:0] lim;
  logic [IW-1:0] r;

  assign mag_b = opb[IW-1] ? IW'(0) - IW'(opb) : IW'(opb);
  assign rs    = {rem[31:0], dv[NB-1]};
  assign qbit  = rs >= {1'b0, ma};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        wide <= req.wide;
        neg  <= opa[31] ^ opb[IW-1];
        zero <= (opa == 32'sd0);
        ma   <= opa[31] ? 32'd0 - 32'(opa) : 32'(opa);
        mb   <= mag_b;
        dv   <= {mag_b, {FRACTION_BITS{1'b0}}};
        acc  <= '0;
        rem  <= '0;
        cnt  <= (req.op == OP_MUL) ? CNTW'(32) : CNTW'(NB);
      end else if (busy) begin
        if (op == OP_MUL) begin
          acc <= (acc << 1) + (ma[31] ? PW'(mb) : PW'(0));
          ma  <= ma << 1;
        end else begin
          rem <= qbit ? rs - {1'b0, ma} : rs;
          acc <= {acc[PW-2:0], qbit};
          dv  <= dv << 1;
        end
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // scale a product back to the fraction point, then clip and restore sign; a zero divisor gives zero
  always_comb begin
    m   = (op == OP_MUL) ? (acc >> FRACTION_BITS) : acc;
    lim = wide ? IMAX : DMAX;
    r   = (m > lim) ? lim[IW-1:0] : m[IW-1:0];
    if (op == OP_DIV && zero) begin
      res = '0;
    end else begin
      res = $signed(neg ? IW'(0) - r : r);
    end
  end

endmodule

@@ hw/rtl/pid_controller_antiwindup.sv @@
// Top level: PID controller with back-calculation anti-windup, Q fixed point.
// Multiplies and divides run one at a time on the one shared unit; init uses up to four
// multiplies and three divides, and a step <= 0 skips the derivative divide.
// Throughput: one item at a time; sample_ready is high only between items.
// Reset (rst, synchronous): clears the state, restores register defaults, drops result_valid.
module pid_controller_antiwindup #(
  parameter int DATA_WIDTH    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  pid_pkg::pid_in_t  sample,
  output logic              result_valid,
  input  logic              result_ready,
  output pid_pkg::pid_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import pid_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int IW = (W + 16 > 62) ? 62 : W + 16;
  localparam int XW = IW + 3;
  localparam logic signed [XW-1:0] DMAX = {{(XW - W + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic signed [XW-1:0] DMIN = ~DMAX;
  localparam logic signed [XW-1:0] IMAX = {{(XW - IW + 1){1'b0}}, {(IW - 1){1'b1}}};
  localparam logic signed [XW-1:0] IMIN = ~IMAX;

  function automatic logic signed [W-1:0] sat_d(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] y;
    y = (x > DMAX) ? DMAX : ((x < DMIN) ? DMIN : x);
    return $signed(y[W-1:0]);
  endfunction

  function automatic logic signed [IW-1:0] sat_i(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] y;
    y = (x > IMAX) ? IMAX : ((x < IMIN) ? IMIN : x);
    return $signed(y[IW-1:0]);
  endfunction

  pid_state_t state, state_next;

  logic signed [31:0] scale, cmin, cmax, kp, ki, kd;
  logic [2:0]         mode;
  logic signed [31:0] refr, meas, dt;
  logic signed [W-1:0]  err, prev_err, derr, pe, de, pd;
  logic signed [IW-1:0] integ;
  logic signed [31:0]   cmdv, last_cmd;
  logic                 lim;
  logic                 pend;

  arith_req_t           req;
  logic signed [31:0]   opa;
  logic signed [IW-1:0] opb;
  logic                 done;
  logic signed [IW-1:0] arith_res;
  logic signed [W-1:0]  res_d;

  logic signed [W-1:0]  sum_sat;
  logic signed [XW-1:0] sum_x;
  logic                 lo_hit, hi_hit;

  assign sample_ready = (state == ST_IDLE);
  assign cfg_ready    = 1'b1;
  assign res_d        = $signed(arith_res[W-1:0]);

  assign sum_sat = sat_d(XW'(pe) + XW'(res_d) + XW'(de));
  assign sum_x   = XW'(sum_sat);
  assign lo_hit  = sum_x <= XW'(cmin);
  assign hi_hit  = sum_x >= XW'(cmax);

  pid_arith #(
    .DATA_WIDTH    (DATA_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_arith (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .opa  (opa),
    .opb  (opb),
    .done (done),
    .res  (arith_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req        = '{start: 1'b0, op: OP_MUL, wide: 1'b0};
    opa        = scale;
    opb        = IW'(refr);
    case (state)
      ST_IDLE: begin
        if (sample_valid) state_next = ST_ERR;
      end
      ST_ERR: begin
        req.start = !pend;
        if (done) state_next = ST_DERR;
      end
      ST_DERR: begin
        req.op = OP_DIV;
        opa    = dt;
        opb    = IW'(sat_d(XW'(err) - XW'(prev_err)));
        if (dt == 32'sd0) begin
          state_next = ST_DISPATCH;
        end else begin
          req.start = !pend;
          if (done) state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (mode)
          MODE_HOLD, MODE_INIT, MODE_ENGAGE: state_next = ST_PE;
          default:                           state_next = ST_OUT;
        endcase
      end
      ST_PE: begin
        opa       = kp;
        opb       = IW'(err);
        req.start = !pend;
        if (done) state_next = ST_DE;
      end
      ST_DE: begin
        opa       = kd;
        opb       = IW'(derr);
        req.start = !pend;
        if (done) begin
          case (mode)
            MODE_INIT:   state_next = ST_PRESET0;
            MODE_ENGAGE: state_next = (ki == 32'sd0) ? ST_IE : ST_INTEG;
            default:     state_next = ST_IE;
          endcase
        end
      end
      ST_PRESET0: begin
        req.op   = OP_DIV;
        req.wide = 1'b1;
        opa      = ki;
        opb      = IW'(sat_d(XW'(0) - XW'(pd)));
        if (ki == 32'sd0) begin
          state_next = ST_IE;
        end else begin
          req.start = !pend;
          if (done) state_next = ST_IE;
        end
      end
      ST_INTEG: begin
        req.wide  = 1'b1;
        opa       = dt;
        opb       = IW'(err);
        req.start = !pend;
        if (done) state_next = ST_IE;
      end
      ST_IE: begin
        opa       = ki;
        opb       = integ;
        req.start = !pend;
        if (done) state_next = (lo_hit || hi_hit) ? ST_PRESET1 : ST_OUT;
      end
      ST_PRESET1: begin
        req.op   = OP_DIV;
        req.wide = 1'b1;
        opa      = ki;
        opb      = IW'(sat_d(XW'(cmdv) - XW'(pd)));
        if (ki == 32'sd0) begin
          state_next = ST_OUT;
        end else begin
          req.start = !pend;
          if (done) state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!result_valid || result_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend         <= 1'b0;
      result_valid <= 1'b0;
      integ        <= '0;
      prev_err     <= '0;
      last_cmd     <= '0;
      scale        <= 32'sd65536;
      cmin         <= -32'sd65536;
      cmax         <= 32'sd65536;
      kp           <= '0;
      ki           <= '0;
      kd           <= '0;
    end else begin
      if (req.start) begin
        pend <= 1'b1;
      end else if (done) begin
        pend <= 1'b0;
      end

      if (cfg_valid) begin
        case (cfg_index)
          CFG_SCALE: scale <= cfg_data;
          CFG_CMIN:  cmin  <= cfg_data;
          CFG_CMAX:  cmax  <= cfg_data;
          CFG_KP:    kp    <= cfg_data;
          CFG_KI:    ki    <= cfg_data;
          CFG_KD:    kd    <= cfg_data;
          default: ;
        endcase
      end

      if (result_valid && result_ready) result_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            mode <= sample.command;
            refr <= sample.reference;
            meas <= sample.measurement;
            // non-positive steps count as zero
            dt   <= (sample.time_step > 32'sd0) ? sample.time_step : 32'sd0;
          end
        end
        ST_ERR: begin
          if (done) err <= sat_d(XW'(res_d) - XW'(meas));
        end
        ST_DERR: begin
          if (dt == 32'sd0) begin
            derr <= '0;
          end else if (done) begin
            derr <= res_d;
          end
        end
        ST_DISPATCH: begin
          prev_err <= err;
          case (mode)
            MODE_RESET: begin
              integ    <= '0;
              prev_err <= '0;
              cmdv     <= '0;
              lim      <= 1'b0;
            end
            MODE_HOLD, MODE_INIT, MODE_ENGAGE: ;
            default: begin
              cmdv <= last_cmd;
              lim  <= 1'b0;
            end
          endcase
        end
        ST_PE: begin
          if (done) pe <= res_d;
        end
        ST_DE: begin
          if (done) begin
            de <= res_d;
            pd <= sat_d(XW'(pe) + XW'(res_d));
            if (mode == MODE_ENGAGE && ki == 32'sd0) integ <= '0;
          end
        end
        ST_PRESET0, ST_PRESET1: begin
          if (ki == 32'sd0) begin
            integ <= '0;
          end else if (done) begin
            integ <= arith_res;
          end
        end
        ST_INTEG: begin
          if (done) integ <= sat_i(XW'(integ) + XW'(arith_res));
        end
        ST_IE: begin
          if (done) begin
            lim <= lo_hit || hi_hit;
            // the lower limit wins when the limits cross
            if (lo_hit) begin
              cmdv <= cmin;
            end else if (hi_hit) begin
              cmdv <= cmax;
            end else begin
              cmdv <= $signed(sum_x[31:0]);
            end
          end
        end
        ST_OUT: begin
          if (!result_valid || result_ready) begin
            result_valid         <= 1'b1;
            result.drive_command <= cmdv;
            result.limited       <= lim;
            last_cmd             <= cmdv;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/pid_checker.sv @@
// Port-level checks for the PID controller, bound to the top level.
`include "assert_macros.svh"

module pid_checker (
  input logic              clk,
  input logic              rst,
  input logic              sample_valid,
  input logic              sample_ready,
  input logic              result_valid,
  input logic              result_ready,
  input pid_pkg::pid_out_t result
);
  import pid_pkg::*;

  // a stalled result word holds
  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, $stable(result), "result word changed while stalled")

  // one word in flight: busy right after an accept
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, sample_valid && sample_ready, !sample_ready, "sample accepted while busy")

  // a new result lands as the block goes back to waiting for input
  `ASSERT_CLKD(a_ready_with_result, clk, rst, $rose(result_valid) |-> sample_ready, "result issued while still busy")

endmodule

bind pid_controller_antiwindup pid_checker u_pid_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

@@ sim/pid_checker.sv @@
// Checker for the PID controller: predicts each output word and compares it.
module pid_scoreboard (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  input  logic              sample_ready,
  input  pid_pkg::pid_in_t  sample,
  input  logic              result_valid,
  input  logic              result_ready,
  input  pid_pkg::pid_out_t result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output int                fail_count,
  output int                pending_count,
  output int                result_count,
  output int                clamp_count
);
  import pid_pkg::*;

  localparam longint DLIM = 64'sd2147483647;
  localparam longint ILIM = 64'sd140737488355327;
  localparam int FB = 16;

  longint r_scale, r_cmin, r_cmax, r_kp, r_ki, r_kd;
  longint integ, prev_err, last_cmd;
  pid_out_t expected_q[$];

  function automatic longint clip(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim - 1) return -lim - 1;
    return x;
  endfunction

  function automatic longint qmul(longint a, longint b, longint lim);
    logic [127:0] p;
    logic [127:0] m;
    longint r;
    p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    m = p >> FB;
    r = (m > 128'(lim)) ? lim : longint'(m);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint qdiv(longint num, longint den, longint lim);
    logic [127:0] n;
    logic [127:0] q;
    longint r;
    if (den == 0) return 0;
    n = 128'(num < 0 ? -num : num) << FB;
    q = n / 128'(den < 0 ? -den : den);
    r = (q > 128'(lim)) ? lim : longint'(q);
    return ((num < 0) != (den < 0)) ? -r : r;
  endfunction

  function automatic void preset_integ(longint c, longint e, longint de);
    longint pd;
    if (r_ki == 0) begin
      integ = 0;
      return;
    end
    pd = clip(qmul(r_kp, e, DLIM) + qmul(r_kd, de, DLIM), DLIM);
    integ = qdiv(clip(c - pd, DLIM), r_ki, ILIM);
  endfunction

  function automatic longint drive_law(longint e, longint de, output logic clamped);
    longint c;
    c = clip(qmul(r_kp, e, DLIM) + qmul(r_ki, integ, DLIM) + qmul(r_kd, de, DLIM), DLIM);
    clamped = 1'b0;
    if (c <= r_cmin) begin
      c = r_cmin;
      clamped = 1'b1;
      preset_integ(c, e, de);
    end else if (c >= r_cmax) begin
      c = r_cmax;
      clamped = 1'b1;
      preset_integ(c, e, de);
    end
    return c;
  endfunction

  function automatic pid_out_t predict_drive(pid_in_t s);
    longint e, de, dt, c;
    logic clamped;
    pid_out_t o;
    clamped = 1'b0;
    dt = longint'(s.time_step);
    e = clip(qmul(r_scale, longint'(s.reference), DLIM) - longint'(s.measurement), DLIM);
    if (dt > 0) begin
      de = qdiv(clip(e - prev_err, DLIM), dt, DLIM);
    end else begin
      dt = 0;
      de = 0;
    end
    prev_err = e;
    case (s.command)
      MODE_RESET: begin
        integ = 0;
        prev_err = 0;
        c = 0;
      end
      MODE_HOLD: c = drive_law(e, de, clamped);
      MODE_INIT: begin
        preset_integ(0, e, de);
        c = drive_law(e, de, clamped);
      end
      MODE_ENGAGE: begin
        if (r_ki != 0) integ = clip(integ + qmul(dt, e, ILIM), ILIM);
        else integ = 0;
        c = drive_law(e, de, clamped);
      end
      default: c = last_cmd;
    endcase
    last_cmd = c;
    o.drive_command = c[31:0];
    o.limited = clamped;
    return o;
  endfunction

  always @(posedge clk) begin
    pid_out_t exp_word;
    if (rst) begin
      r_scale = 65536; r_cmin = -65536; r_cmax = 65536;
      r_kp = 0; r_ki = 0; r_kd = 0;
      integ = 0; prev_err = 0; last_cmd = 0;
      expected_q.delete();
      fail_count <= 0; pending_count <= 0; result_count <= 0; clamp_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SCALE: r_scale = longint'($signed(cfg_data));
          CFG_CMIN:  r_cmin  = longint'($signed(cfg_data));
          CFG_CMAX:  r_cmax  = longint'($signed(cfg_data));
          CFG_KP:    r_kp    = longint'($signed(cfg_data));
          CFG_KI:    r_ki    = longint'($signed(cfg_data));
          CFG_KD:    r_kd    = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      if (sample_valid && sample_ready) expected_q.push_back(predict_drive(sample));
      if (result_valid && result_ready) begin
        result_count <= result_count + 1;
        if (result.limited) clamp_count <= clamp_count + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, result);
          fail_count <= fail_count + 1;
        end else begin
          exp_word = expected_q.pop_front();
          if (exp_word.drive_command !== result.drive_command ||
              exp_word.limited !== result.limited) begin
            $display("%0t: mismatch expected cmd=%0d lim=%0b actual cmd=%0d lim=%0b",
                     $time, exp_word.drive_command, exp_word.limited,
                     result.drive_command, result.limited);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= expected_q.size();
    end
  end
endmodule

@@ sim/tb_top.sv @@
// Stimulus and verdict for the PID controller testbench.
module tb_top;
  import pid_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0, sample_ready;
  pid_in_t sample = '0;
  logic result_valid, result_ready = 1'b0;
  pid_out_t result;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int fail_count, pending_count, result_count, clamp_count;
  bit stall_long = 1'b0;
  bit stim_done = 1'b0;

  always #6 clk = ~clk;

  pid_controller_antiwindup uut (.*);
  pid_scoreboard chk (.*);

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3, 4: return $urandom;
      default: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(logic [2:0] mode, logic [31:0] ref_v, logic [31:0] meas,
                           logic [31:0] dt);
    int gap;
    gap = $urandom_range(0, 4);
    repeat (gap) @(negedge clk);
    sample <= '{mode, ref_v, meas, dt};
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
    sample_valid <= 1'b0;
  endtask

  // drain results, then let the block settle before touching registers
  task automatic wait_idle();
    while (pending_count != 0 || sample_valid) @(negedge clk);
    repeat (400) @(negedge clk);
  endtask

  always begin
    int wait_cycles;
    @(negedge clk);
    if (rst || stall_long) begin
      result_ready <= 1'b0;
    end else begin
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      result_ready <= 1'b0;
      repeat (wait_cycles) @(negedge clk);
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  initial begin
    #60000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic [31:0] regs [6];
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed: defaults first, every mode and the special cases
    send_word(MODE_ENGAGE, 32'h7fffffff, 32'h80000000, 32'h00010000);
    send_word(MODE_STANDBY, 0, 0, 0);
    send_word(3'd7, 32'h80000000, 32'h7fffffff, 32'h80000000);
    send_word(3'd5, 1, 2, 3);
    send_word(3'd6, 1, 2, 3);
    wait_idle();
    write_reg(CFG_KP, 32'h00008000);
    write_reg(CFG_KI, 32'h00020000);
    write_reg(CFG_KD, 32'h00001000);
    write_reg(CFG_SCALE, 32'h00010000);
    write_reg(CFG_CMIN, 32'hfffe0000);
    write_reg(CFG_CMAX, 32'h00020000);
    write_reg(3'd7, 32'h12345678);
    send_word(MODE_INIT, 32'h00010000, 32'h00008000, 32'h00000100);
    send_word(MODE_ENGAGE, 32'h00010000, 32'h00004000, 32'h00000100);
    send_word(MODE_ENGAGE, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    send_word(MODE_HOLD, 32'h00010000, 0, 32'hffffffff);
    send_word(MODE_HOLD, 32'h80000000, 32'h7fffffff, 0);
    send_word(MODE_STANDBY, 5, 5, 5);
    send_word(MODE_RESET, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_word(MODE_ENGAGE, 32'h00001000, 32'hffff0000, 32'h00000001);
    wait_idle();
    // minimum above maximum
    write_reg(CFG_CMIN, 32'h00010000);
    write_reg(CFG_CMAX, 32'hffff0000);
    write_reg(CFG_KI, 32'h0);
    send_word(MODE_ENGAGE, 32'h00020000, 0, 32'h00000100);
    send_word(MODE_HOLD, 32'hfff00000, 0, 32'h00000100);
    send_word(MODE_INIT, 0, 0, 0);
    wait_idle();
    // long receiver stall while the sender keeps offering
    fork
      begin
        stall_long = 1'b1;
        repeat (3000) @(negedge clk);
        stall_long = 1'b0;
      end
      repeat (6) send_word(MODE_ENGAGE, $urandom, $urandom, $urandom);
    join
    wait_idle();
    for (int ph = 0; ph < 8; ph++) begin
      for (int r = 0; r < 6; r++) regs[r] = pick_value();
      if (ph == 0) begin
        regs[1] = 32'h80000000; regs[2] = 32'h7fffffff;
      end else if (ph == 1) begin
        regs[0] = 32'h7fffffff; regs[3] = 32'h80000000;
        regs[4] = 32'h7fffffff; regs[5] = 32'h80000000;
      end else if (ph % 2 == 0 && $signed(regs[1]) > $signed(regs[2])) begin
        regs[1] = regs[2] - 32'h10000;
      end
      for (int r = 0; r < 6; r++) write_reg(3'(r), regs[r]);
      for (int n = 0; n < 105; n++) begin
        // mostly engaged runs with small steps, sprinkled with other modes
        case ($urandom_range(0, 19))
          0: send_word(MODE_RESET, pick_value(), pick_value(), pick_value());
          1: send_word(MODE_STANDBY, pick_value(), pick_value(), pick_value());
          2: send_word(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom);
          3, 4: send_word(MODE_HOLD, pick_value(), pick_value(), pick_value());
          5: send_word(MODE_INIT, pick_value(), pick_value(), pick_value());
          default: send_word(MODE_ENGAGE, pick_value(), pick_value(),
                             ($urandom_range(0, 7) == 0) ? pick_value()
                                                         : $urandom_range(1, 2000));
        endcase
      end
      wait_idle();
    end
    $display("Ran %0d output words, %0d clamped, across 11 register settings.",
             result_count, clamp_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
